// ===== rtl/qts_pkg.sv =====
// Package for the quoted token splitter.
// Holds character constants, register indexes and the queue entry type.
// No dependencies.
package qts_pkg;

   localparam int QueueDepthDefault = 4;

   localparam logic [7:0] SEP_RESET   = 8'h20;
   localparam logic [8:0] LIMIT_RESET = 9'h1FF;

   localparam logic CSR_SEPARATOR   = 1'b0;
   localparam logic CSR_SPLIT_LIMIT = 1'b1;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_ESC    = 8'h1B;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_E  = 8'h65;

   // One queue entry: a first result, optionally followed by a second
   // result that always carries second_byte as a plain token byte.
   typedef struct packed {
      logic [7:0] token_byte;
      logic       byte_valid;
      logic       token_done;
      logic       text_done;
      logic       has_second;
      logic [7:0] second_byte;
   } entry_type;

endpackage

// ===== rtl/qts_front.sv =====
// Front end of the quoted token splitter: config registers, parse state,
// classification of each request into a queue entry. Uses qts_pkg.
module qts_front
   import qts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [8:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_text_byte,
   input  logic       req_terminator,
   input  logic       q_full,
   output logic       q_push,
   output entry_type  q_push_data
);

   logic [7:0] separator_ff;
   logic [8:0] split_limit_ff;

   logic       inq_ff, inq_in;
   logic       esc_ff, esc_in;
   logic       seen_ff, seen_in;
   logic       has_ff, has_in;
   logic [7:0] count_ff, count_in;

   logic              accept;
   logic              emit;
   logic              active;
   logic signed [9:0] cnt_ext;
   logic signed [9:0] lim_m1;
   logic [7:0]        b;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign q_push    = accept && emit;
   assign b         = req_text_byte;

   assign cnt_ext = $signed({2'b00, count_ff});
   assign lim_m1  = $signed({split_limit_ff[8], split_limit_ff}) - 10'sd1;
   assign active  = split_limit_ff[8] || (cnt_ext < lim_m1);

   always_ff @(posedge clock) begin
      if (reset) begin
         separator_ff   <= SEP_RESET;
         split_limit_ff <= LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SEPARATOR:   separator_ff   <= csr_write_data[7:0];
            CSR_SPLIT_LIMIT: split_limit_ff <= csr_write_data;
            default:         separator_ff   <= separator_ff;
         endcase
      end
   end

   always_comb begin
      inq_in      = inq_ff;
      esc_in      = esc_ff;
      seen_in     = seen_ff;
      has_in      = has_ff;
      count_in    = count_ff;
      emit        = 1'b0;
      q_push_data = '0;

      if (req_terminator) begin
         emit                   = 1'b1;
         q_push_data.text_done  = 1'b1;
         if (esc_ff) begin
            q_push_data.token_byte = CH_BSLASH;
            q_push_data.byte_valid = 1'b1;
            q_push_data.token_done = 1'b1;
         end else if (has_ff || seen_ff) begin
            q_push_data.token_done = 1'b1;
         end
         inq_in   = 1'b0;
         esc_in   = 1'b0;
         seen_in  = 1'b0;
         has_in   = 1'b0;
         count_in = '0;
      end else if (esc_ff) begin
         emit                   = 1'b1;
         esc_in                 = 1'b0;
         has_in                 = 1'b1;
         q_push_data.byte_valid = 1'b1;
         case (b)
            CH_LOW_N:  q_push_data.token_byte = CH_LF;
            CH_LOW_R:  q_push_data.token_byte = CH_CR;
            CH_LOW_E:  q_push_data.token_byte = CH_ESC;
            CH_QUOTE:  q_push_data.token_byte = CH_QUOTE;
            CH_BSLASH: q_push_data.token_byte = CH_BSLASH;
            default: begin
               // unknown escape: backslash, then the byte as is
               q_push_data.token_byte  = CH_BSLASH;
               q_push_data.has_second  = 1'b1;
               q_push_data.second_byte = b;
            end
         endcase
      end else if (inq_ff && b == CH_BSLASH) begin
         esc_in = 1'b1;
      end else if (b == CH_QUOTE && active) begin
         inq_in = !inq_ff;
         if (inq_ff) begin
            seen_in = 1'b1;
         end
      end else if ((!inq_ff && b == separator_ff) || b == CH_NUL) begin
         if (active || b == CH_NUL) begin
            if (has_ff || seen_ff) begin
               emit                   = 1'b1;
               q_push_data.token_done = 1'b1;
               seen_in                = 1'b0;
               has_in                 = 1'b0;
               if (count_ff != 8'hFF) begin
                  count_in = count_ff + 8'd1;
               end
            end
         end else begin
            emit                   = 1'b1;
            has_in                 = 1'b1;
            q_push_data.token_byte = separator_ff;
            q_push_data.byte_valid = 1'b1;
         end
      end else begin
         emit                   = 1'b1;
         has_in                 = 1'b1;
         q_push_data.token_byte = b;
         q_push_data.byte_valid = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inq_ff   <= 1'b0;
         esc_ff   <= 1'b0;
         seen_ff  <= 1'b0;
         has_ff   <= 1'b0;
         count_ff <= '0;
      end else if (accept) begin
         inq_ff   <= inq_in;
         esc_ff   <= esc_in;
         seen_ff  <= seen_in;
         has_ff   <= has_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/qts_queue.sv =====
// Short queue of entries between front and back of the token splitter.
// Register array with wrapping pointers. Uses qts_pkg.
module qts_queue
   import qts_pkg::*;
#(
   parameter int DEPTH = QueueDepthDefault
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output entry_type pop_data,
   output logic      empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastIdx = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   entry_type     mem [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] count_ff;

   assign full     = (count_ff == FullCnt);
   assign empty    = (count_ff == '0);
   assign pop_data = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LastIdx) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LastIdx) ? '0 : rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ===== rtl/qts_back.sv =====
// Back end of the token splitter: unpacks queue entries into one or two
// responses and holds them in the output register. Uses qts_pkg.
module qts_back
   import qts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  entry_type  q_pop_data,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_token_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_token_done,
   output logic       rsp_text_done,
   output logic       sec_pending
);

   logic       valid_ff, valid_in;
   logic       sec_ff, sec_in;
   logic [7:0] sec_byte_ff, sec_byte_in;
   logic [7:0] byte_ff, byte_in;
   logic       bv_ff, bv_in;
   logic       td_ff, td_in;
   logic       xd_ff, xd_in;
   logic       out_free;

   assign out_free = !valid_ff || rsp_ready;
   assign q_pop    = !q_empty && !sec_ff && out_free;

   always_comb begin
      valid_in    = valid_ff;
      sec_in      = sec_ff;
      sec_byte_in = sec_byte_ff;
      byte_in     = byte_ff;
      bv_in       = bv_ff;
      td_in       = td_ff;
      xd_in       = xd_ff;
      if (q_pop) begin
         valid_in    = 1'b1;
         byte_in     = q_pop_data.token_byte;
         bv_in       = q_pop_data.byte_valid;
         td_in       = q_pop_data.token_done;
         xd_in       = q_pop_data.text_done;
         sec_in      = q_pop_data.has_second;
         sec_byte_in = q_pop_data.second_byte;
      end else if (valid_ff && rsp_ready) begin
         if (sec_ff) begin
            byte_in = sec_byte_ff;
            bv_in   = 1'b1;
            td_in   = 1'b0;
            xd_in   = 1'b0;
            sec_in  = 1'b0;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sec_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sec_ff   <= sec_in;
      end
   end

   always_ff @(posedge clock) begin
      sec_byte_ff <= sec_byte_in;
      byte_ff     <= byte_in;
      bv_ff       <= bv_in;
      td_ff       <= td_in;
      xd_ff       <= xd_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_token_byte = byte_ff;
   assign rsp_byte_valid = bv_ff;
   assign rsp_token_done = td_ff;
   assign rsp_text_done  = xd_ff;
   assign sec_pending    = sec_ff;

endmodule

// ===== rtl/quoted_token_splitter_top.sv =====
// Quoted token splitter: one request per cycle while the queue has room;
// responses pass the queue, then the output register, two for an unmapped
// escape. The single output register sets throughput: one response per cycle
// while rsp_ready is high. Synchronous active-high reset clears parse state,
// queue, output valid; separator returns to space, split limit to unlimited.
module quoted_token_splitter_top
   import qts_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepthDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [8:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_text_byte,
   input  logic       req_terminator,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_token_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_token_done,
   output logic       rsp_text_done
);

   logic      q_push, q_full, q_pop, q_empty;
   entry_type q_push_data, q_pop_data;
   logic      sec_pending;

   qts_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .req_terminator   (req_terminator),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_push_data      (q_push_data)
   );

   qts_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   qts_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_pop_data     (q_pop_data),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_token_byte (rsp_token_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_token_done (rsp_token_done),
      .rsp_text_done  (rsp_text_done),
      .sec_pending    (sec_pending)
   );

`ifndef SYNTH
   // a response without a byte must close a token or the text
   a_empty_rsp_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |->
         rsp_token_byte == 8'h00 && (rsp_token_done || rsp_text_done))
      else $error("byteless response closes nothing");

   // while the escaped byte waits, the backslash is on the output
   a_second_behind_bslash: assert property (@(posedge clock) disable iff (reset)
      sec_pending |-> rsp_valid && rsp_byte_valid && !rsp_token_done &&
         rsp_token_byte == CH_BSLASH)
      else $error("pending second byte without backslash in front");

   // draining the last response with nothing queued leaves the output idle
   a_drain_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && q_empty && !sec_pending |=> !rsp_valid)
      else $error("response appeared from an empty queue");
`endif

endmodule

// ===== bench/tb_quoted_token_splitter_top.sv =====
// Self-checking bench for quoted_token_splitter_top: drives text bytes and terminators,
// predicts the token stream in step with every accepted request and checks each response.
// Depends on qts_pkg and the quoted_token_splitter_top RTL.
`timescale 1ns / 100ps

module tb_quoted_token_splitter_top;
   import qts_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int LONG_HOLD      = 250;
   localparam int ITEM_TARGET    = 1450;

   typedef struct packed {
      logic [7:0] token_byte;
      logic       byte_valid;
      logic       token_done;
      logic       text_done;
   } token_result_type;

   typedef enum int {RX_STREAM, RX_HALF, RX_SLOW} rx_mode_type;

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic       csr_index;
   logic [8:0] csr_write_data;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_text_byte;
   logic       req_terminator;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_token_byte;
   logic       rsp_byte_valid;
   logic       rsp_token_done;
   logic       rsp_text_done;

   // predictor state, mirrors the block after reset
   logic [7:0] sep_byte       = SEP_RESET;
   int         limit_value    = -1;
   logic       quoted_open    = 1'b0;
   logic       escape_open    = 1'b0;
   logic       quote_closed   = 1'b0;
   logic       token_nonempty = 1'b0;
   logic [7:0] tokens_closed  = 8'd0;

   token_result_type expected_tokens[$];
   int  mismatch_count = 0;
   int  items_sent     = 0;
   int  burst_left     = 0;
   bit  gaps_on        = 1'b1;
   bit  hold_request   = 1'b0;
   int  idle_cycles    = 0;

   quoted_token_splitter_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .req_terminator   (req_terminator),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_byte   (rsp_token_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_token_done   (rsp_token_done),
      .rsp_text_done    (rsp_text_done)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void push_token(input logic [7:0] b, input logic bv, input logic td,
                                      input logic xd);
      token_result_type r;
      r.token_byte = b;
      r.byte_valid = bv;
      r.token_done = td;
      r.text_done  = xd;
      expected_tokens.insert(expected_tokens.size(), r);
   endfunction

   // Advances the splitter state by one request and queues the responses it causes.
   function automatic void predict_tokens(input logic [7:0] b, input logic term);
      logic splitting;
      splitting = (limit_value < 0) || (int'(tokens_closed) < limit_value - 1);
      if (term) begin
         if (escape_open)
            push_token(CH_BSLASH, 1'b1, 1'b1, 1'b1);
         else if (token_nonempty || quote_closed)
            push_token(CH_NUL, 1'b0, 1'b1, 1'b1);
         else
            push_token(CH_NUL, 1'b0, 1'b0, 1'b1);
         quoted_open    = 1'b0;
         escape_open    = 1'b0;
         quote_closed   = 1'b0;
         token_nonempty = 1'b0;
         tokens_closed  = 8'd0;
         return;
      end
      if (escape_open) begin
         escape_open    = 1'b0;
         token_nonempty = 1'b1;
         case (b)
            CH_LOW_N:  push_token(CH_LF, 1'b1, 1'b0, 1'b0);
            CH_LOW_R:  push_token(CH_CR, 1'b1, 1'b0, 1'b0);
            CH_LOW_E:  push_token(CH_ESC, 1'b1, 1'b0, 1'b0);
            CH_QUOTE:  push_token(CH_QUOTE, 1'b1, 1'b0, 1'b0);
            CH_BSLASH: push_token(CH_BSLASH, 1'b1, 1'b0, 1'b0);
            default: begin
               // unmapped escape keeps the backslash as its own byte
               push_token(CH_BSLASH, 1'b1, 1'b0, 1'b0);
               push_token(b, 1'b1, 1'b0, 1'b0);
            end
         endcase
         return;
      end
      if (quoted_open && b == CH_BSLASH) begin
         escape_open = 1'b1;
         return;
      end
      if (b == CH_QUOTE && splitting) begin
         quoted_open = ~quoted_open;
         if (!quoted_open)
            quote_closed = 1'b1;
         return;
      end
      if ((!quoted_open && b == sep_byte) || b == CH_NUL) begin
         if (splitting || b == CH_NUL) begin
            if (token_nonempty || quote_closed) begin
               quote_closed   = 1'b0;
               token_nonempty = 1'b0;
               if (tokens_closed != 8'hFF)
                  tokens_closed = tokens_closed + 8'd1;
               push_token(CH_NUL, 1'b0, 1'b1, 1'b0);
            end
            return;
         end
         token_nonempty = 1'b1;
         push_token(sep_byte, 1'b1, 1'b0, 1'b0);
         return;
      end
      token_nonempty = 1'b1;
      push_token(b, 1'b1, 1'b0, 1'b0);
   endfunction

   function automatic void compare_field(input string name, input logic [7:0] exp_val,
                                         input logic [7:0] act_val);
      if (exp_val !== act_val) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
      end
   endfunction

   // response checker
   always @(posedge clock) begin
      token_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_tokens.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected response, expected none, actual %h/%b/%b/%b", $time,
                     rsp_token_byte, rsp_byte_valid, rsp_token_done, rsp_text_done);
         end else begin
            want = expected_tokens.pop_front();
            compare_field("token_byte", want.token_byte, rsp_token_byte);
            compare_field("byte_valid", want.byte_valid, rsp_byte_valid);
            compare_field("token_done", want.token_done, rsp_token_done);
            compare_field("text_done", want.text_done, rsp_text_done);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver: phases of streaming, light and heavy stalls, plus an on-demand long hold
   initial begin
      int          phase_left;
      int          hold_left;
      rx_mode_type rx_mode;
      rsp_ready  = 1'b0;
      phase_left = 0;
      hold_left  = 0;
      rx_mode    = RX_STREAM;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
         end
         if (phase_left == 0) begin
            rx_mode    = rx_mode_type'($urandom_range(0, 2));
            phase_left = $urandom_range(20, 200);
         end
         phase_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_STREAM: rsp_ready <= 1'b1;
               RX_HALF:   rsp_ready <= 1'($urandom_range(0, 1));
               default:   rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   task automatic send_request(input logic [7:0] b, input logic term);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         if (gaps_on) begin
            gap = $urandom_range(1, 8);
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_text_byte  <= b;
      req_terminator <= term;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_tokens(b, term);
      items_sent++;
   endtask

   task automatic send_text_byte(input logic [7:0] b);
      send_request(b, 1'b0);
   endtask

   task automatic end_text();
      send_request(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // drop valid, let all responses drain, then cover requests that leave no response
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [8:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_SEPARATOR)
         sep_byte = data[7:0];
      else
         limit_value = $signed(data);
   endtask

   task automatic configure(input logic [7:0] sep, input logic [8:0] limit);
      wait_idle();
      write_csr(CSR_SEPARATOR, {1'($urandom_range(0, 1)), sep});
      write_csr(CSR_SPLIT_LIMIT, limit);
   endtask

   function automatic logic [7:0] pick_text_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 12) return sep_byte;
      if (r < 22) return CH_QUOTE;
      if (r < 32) return CH_BSLASH;
      if (r < 36) return CH_NUL;
      if (r < 44) begin
         case ($urandom_range(0, 2))
            0:       return CH_LOW_N;
            1:       return CH_LOW_R;
            default: return CH_LOW_E;
         endcase
      end
      if (r < 70) return 8'($urandom_range(8'h61, 8'h7A));
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_random_text(input int len);
      repeat (len) send_text_byte(pick_text_byte());
      end_text();
   endtask

   // all escapes, empty tokens, byte zero and every terminator case at reset config
   task automatic test_escapes_and_quotes();
      logic [7:0] seq[$];
      seq = '{CH_QUOTE, CH_BSLASH, CH_LOW_N, CH_BSLASH, CH_LOW_R, CH_BSLASH, CH_LOW_E,
              CH_BSLASH, CH_QUOTE, CH_BSLASH, CH_BSLASH, CH_BSLASH, 8'h78,
              CH_BSLASH, CH_NUL, 8'h20, CH_NUL, CH_QUOTE, 8'h20, 8'h20, 8'hFF, CH_NUL};
      foreach (seq[i]) send_text_byte(seq[i]);
      end_text();
      send_text_byte(8'h61);
      end_text();
      send_text_byte(CH_QUOTE);
      send_text_byte(CH_BSLASH);
      end_text();
      send_text_byte(CH_QUOTE);
      send_text_byte(CH_QUOTE);
      end_text();
   endtask

   // separators and quotes turn literal after the limit; byte zero still closes
   task automatic test_split_limit();
      configure(8'hFF, 9'd2);
      send_text_byte(8'h61);
      send_text_byte(8'hFF);
      send_text_byte(8'h62);
      send_text_byte(8'hFF);
      send_text_byte(CH_QUOTE);
      send_text_byte(CH_NUL);
      send_text_byte(8'h63);
      end_text();
      configure(8'h20, 9'd0);
      send_text_byte(CH_QUOTE);
      send_text_byte(8'h78);
      send_text_byte(8'h20);
      send_text_byte(CH_BSLASH);
      send_text_byte(CH_NUL);
      end_text();
   endtask

   // enough closes in one text to run the token count into saturation
   task automatic test_long_text();
      configure(8'h2C, 9'd255);
      for (int i = 0; i < 280; i++) begin
         repeat ($urandom_range(1, 2)) send_text_byte(8'($urandom_range(8'h41, 8'h5A)));
         if (i >= 250 && $urandom_range(0, 2) == 0)
            send_text_byte(($urandom_range(0, 1) == 0) ? CH_QUOTE : sep_byte);
         if (i >= 240 || i % 3 == 0)
            send_text_byte(CH_NUL);
         else
            send_text_byte(sep_byte);
      end
      end_text();
   endtask

   // receiver holds off while the sender streams, then the sender waits for a full drain
   task automatic test_backpressure();
      configure(8'h20, 9'h1FF);
      hold_request = 1'b1;
      gaps_on      = 1'b0;
      send_random_text(40);
      send_random_text(20);
      gaps_on = 1'b1;
      wait_idle();
   endtask

   task automatic test_random_texts();
      logic [8:0] limit;
      logic [7:0] sep;
      int         text_idx;
      text_idx = 0;
      while (items_sent < ITEM_TARGET) begin
         case (text_idx)
            0: configure(8'h00, 9'h100);
            1: configure(8'hFF, 9'd255);
            2: configure(8'h2C, 9'd0);
            3: configure(8'h20, 9'h1FF);
            default: begin
               if ($urandom_range(0, 2) == 0) begin
                  case ($urandom_range(0, 6))
                     0:       sep = 8'h20;
                     1:       sep = 8'h2C;
                     2:       sep = CH_NUL;
                     3:       sep = 8'hFF;
                     4:       sep = CH_QUOTE;
                     5:       sep = CH_BSLASH;
                     default: sep = 8'($urandom_range(0, 255));
                  endcase
                  case ($urandom_range(0, 5))
                     0:       limit = 9'h1FF;
                     1:       limit = 9'($urandom_range(0, 6));
                     2:       limit = 9'd255;
                     3:       limit = 9'h100;
                     default: limit = 9'($urandom_range(0, 511));
                  endcase
                  configure(sep, limit);
               end
            end
         endcase
         text_idx++;
         send_random_text($urandom_range(1, 30));
      end
   endtask

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_SEPARATOR;
      csr_write_data   = 9'd0;
      req_valid        = 1'b0;
      req_text_byte    = 8'd0;
      req_terminator   = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_escapes_and_quotes();
      test_split_limit();
      test_long_text();
      test_backpressure();
      test_random_texts();
      wait_idle();

      if (mismatch_count == 0 && expected_tokens.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/qts_pkg.sv
rtl/qts_front.sv
rtl/qts_queue.sv
rtl/qts_back.sv
rtl/quoted_token_splitter_top.sv
bench/tb_quoted_token_splitter_top.sv
